// ===== src/ray_box_plucker_test_defines.svh =====
// assertion macros for the ray versus box test block
`ifndef RAY_BOX_PLUCKER_TEST_DEFINES_SVH
`define RAY_BOX_PLUCKER_TEST_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RBPT_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rbpt check failed");

// next-cycle implication, checked outside reset
`define RBPT_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rbpt check failed");

`endif

// ===== src/rbpt_pkg.sv =====
// shared constants and types of the ray versus box test block
`default_nettype none

package rbpt_pkg;

  localparam int COORD_BITS_DEF  = 24;
  localparam int DIR_BITS_DEF    = 18;
  localparam int PLK_BITS        = 48;
  localparam int SIGN_BITS       = 3;
  localparam int REG_IDX_BITS    = 3;
  localparam int OUT_TDATA_BITS  = 8;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_BOX_EMPTY,
    REG_BOX_X_LOW,
    REG_BOX_X_HIGH,
    REG_BOX_Y_LOW,
    REG_BOX_Y_HIGH,
    REG_BOX_Z_LOW,
    REG_BOX_Z_HIGH
  } reg_idx_t;

  typedef struct packed {
    logic load1;
    logic load2;
  } stage_en_t;

endpackage

`default_nettype wire

// ===== src/rbpt_edge.sv =====
// pair of plucker side tests for one coefficient, two pipeline stages
`default_nettype none

module rbpt_edge #(
  parameter int COORD_BITS = rbpt_pkg::COORD_BITS_DEF,
  parameter int DIR_BITS   = rbpt_pkg::DIR_BITS_DEF
) (
  input  wire                             clk,
  input  wire rbpt_pkg::stage_en_t        en,
  input  wire signed [rbpt_pkg::PLK_BITS-1:0] coef,
  input  wire signed [DIR_BITS-1:0]       a,
  input  wire                             sa,
  input  wire signed [COORD_BITS-1:0]     p_lo,
  input  wire signed [COORD_BITS-1:0]     p_hi,
  input  wire signed [DIR_BITS-1:0]       b,
  input  wire                             sb,
  input  wire signed [COORD_BITS-1:0]     q_lo,
  input  wire signed [COORD_BITS-1:0]     q_hi,
  output logic                            miss
);

  localparam int PW = COORD_BITS + DIR_BITS;
  localparam int SW = ((PW > rbpt_pkg::PLK_BITS) ? PW : rbpt_pkg::PLK_BITS) + 2;

  logic signed [COORD_BITS-1:0] p1, q1, p2, q2;
  logic signed [PW-1:0] prod_a1, prod_b1, prod_a2, prod_b2;
  logic signed [rbpt_pkg::PLK_BITS-1:0] coef1;
  logic signed [SW-1:0] sum1, sum2;

  always_comb begin
    p1 = sa ? p_hi : p_lo;
    q1 = sb ? q_lo : q_hi;
    p2 = sa ? p_lo : p_hi;
    q2 = sb ? q_hi : q_lo;
  end

  // products
  always_ff @(posedge clk) begin
    if (en.load1) begin
      prod_a1 <= PW'(a) * PW'(p1);
      prod_b1 <= PW'(b) * PW'(q1);
      prod_a2 <= PW'(a) * PW'(p2);
      prod_b2 <= PW'(b) * PW'(q2);
      coef1   <= coef;
    end
  end

  // sums
  always_ff @(posedge clk) begin
    if (en.load2) begin
      sum1 <= SW'(coef1) + SW'(prod_a1) - SW'(prod_b1);
      sum2 <= SW'(coef1) + SW'(prod_a2) - SW'(prod_b2);
    end
  end

  assign miss = sum1[SW-1] | (~sum2[SW-1] & (sum2 != '0));

endmodule

`default_nettype wire

// ===== src/ray_box_plucker_test.sv =====
// ray versus axis-aligned box test with plucker side tests
// throughput: one ray per cycle while the output is not stalled, four register stages (input, products, sums, result)
// a stalled output backs up stage by stage; empty stages still take new beats
// reset: synchronous, clears all valid bits, box_empty to 1, box bounds to 0
`default_nettype none

module ray_box_plucker_test #(
  parameter int COORD_BITS = rbpt_pkg::COORD_BITS_DEF,
  parameter int DIR_BITS   = rbpt_pkg::DIR_BITS_DEF,
  localparam int IN_BITS   = 3 * COORD_BITS + 3 * DIR_BITS + 3 * rbpt_pkg::PLK_BITS,
  localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, plucker_xy, plucker_xz, plucker_yz
  input  wire [IN_TDATA_BITS-1:0]               s_axis_tdata,
  // sign_class
  input  wire [rbpt_pkg::SIGN_BITS-1:0]         s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // hit
  output logic [rbpt_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,
  input  wire                                   cfg_we,
  input  wire [rbpt_pkg::REG_IDX_BITS-1:0]      cfg_idx,
  input  wire [COORD_BITS-1:0]                  cfg_data
);

  localparam int PLK    = rbpt_pkg::PLK_BITS;
  localparam int OFF_DX = 3 * COORD_BITS;
  localparam int OFF_PK = 3 * COORD_BITS + 3 * DIR_BITS;

  // configuration
  logic box_empty;
  logic signed [COORD_BITS-1:0] xl, xh, yl, yh, zl, zh;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_empty <= 1'b1;
      xl <= '0;
      xh <= '0;
      yl <= '0;
      yh <= '0;
      zl <= '0;
      zh <= '0;
    end else if (cfg_we) begin
      case (rbpt_pkg::reg_idx_t'(cfg_idx))
        rbpt_pkg::REG_BOX_EMPTY:  box_empty <= cfg_data[0];
        rbpt_pkg::REG_BOX_X_LOW:  xl <= cfg_data;
        rbpt_pkg::REG_BOX_X_HIGH: xh <= cfg_data;
        rbpt_pkg::REG_BOX_Y_LOW:  yl <= cfg_data;
        rbpt_pkg::REG_BOX_Y_HIGH: yh <= cfg_data;
        rbpt_pkg::REG_BOX_Z_LOW:  zl <= cfg_data;
        rbpt_pkg::REG_BOX_Z_HIGH: zh <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage handshake
  logic v0, v1, v2, v3;
  logic rdy0, rdy1, rdy2, rdy3;

  always_comb begin
    rdy3 = ~v3 | m_axis_tready;
    rdy2 = ~v2 | rdy3;
    rdy1 = ~v1 | rdy2;
    rdy0 = ~v0 | rdy1;
  end

  assign s_axis_tready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy0) v0 <= s_axis_tvalid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // stage 0: input beat
  logic signed [COORD_BITS-1:0] ox0, oy0, oz0;
  logic signed [DIR_BITS-1:0]   dx0, dy0, dz0;
  logic signed [PLK-1:0]        pxy0, pxz0, pyz0;
  logic [rbpt_pkg::SIGN_BITS-1:0] sc0;

  always_ff @(posedge clk) begin
    if (rdy0) begin
      ox0  <= s_axis_tdata[0 +: COORD_BITS];
      oy0  <= s_axis_tdata[COORD_BITS +: COORD_BITS];
      oz0  <= s_axis_tdata[2 * COORD_BITS +: COORD_BITS];
      dx0  <= s_axis_tdata[OFF_DX +: DIR_BITS];
      dy0  <= s_axis_tdata[OFF_DX + DIR_BITS +: DIR_BITS];
      dz0  <= s_axis_tdata[OFF_DX + 2 * DIR_BITS +: DIR_BITS];
      pxy0 <= s_axis_tdata[OFF_PK +: PLK];
      pxz0 <= s_axis_tdata[OFF_PK + PLK +: PLK];
      pyz0 <= s_axis_tdata[OFF_PK + 2 * PLK +: PLK];
      sc0  <= s_axis_tuser;
    end
  end

  // slab tests on the origin
  logic slab_miss;
  logic pre_miss1, pre_miss2;

  always_comb begin
    slab_miss = (sc0[2] ? (ox0 > xh) : (ox0 < xl))
              | (sc0[1] ? (oy0 > yh) : (oy0 < yl))
              | (sc0[0] ? (oz0 > zh) : (oz0 < zl));
  end

  always_ff @(posedge clk) begin
    if (rdy1) pre_miss1 <= box_empty | slab_miss;
    if (rdy2) pre_miss2 <= pre_miss1;
  end

  // edge tests
  rbpt_pkg::stage_en_t en;
  logic miss_xy, miss_xz, miss_yz;

  assign en.load1 = rdy1;
  assign en.load2 = rdy2;

  rbpt_edge #(.COORD_BITS(COORD_BITS), .DIR_BITS(DIR_BITS)) u_edge_xy (
    .clk(clk), .en(en), .coef(pxy0),
    .a(dx0), .sa(sc0[2]), .p_lo(yl), .p_hi(yh),
    .b(dy0), .sb(sc0[1]), .q_lo(xl), .q_hi(xh),
    .miss(miss_xy)
  );

  rbpt_edge #(.COORD_BITS(COORD_BITS), .DIR_BITS(DIR_BITS)) u_edge_xz (
    .clk(clk), .en(en), .coef(pxz0),
    .a(dx0), .sa(sc0[2]), .p_lo(zl), .p_hi(zh),
    .b(dz0), .sb(sc0[0]), .q_lo(xl), .q_hi(xh),
    .miss(miss_xz)
  );

  rbpt_edge #(.COORD_BITS(COORD_BITS), .DIR_BITS(DIR_BITS)) u_edge_yz (
    .clk(clk), .en(en), .coef(pyz0),
    .a(dy0), .sa(sc0[1]), .p_lo(zl), .p_hi(zh),
    .b(dz0), .sb(sc0[0]), .q_lo(yl), .q_hi(yh),
    .miss(miss_yz)
  );

  // stage 3: result
  logic hit3;

  always_ff @(posedge clk) begin
    if (rdy3) hit3 <= ~(pre_miss2 | miss_xy | miss_xz | miss_yz);
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = {(rbpt_pkg::OUT_TDATA_BITS - 1)'(0), hit3};

endmodule

`default_nettype wire

// ===== src/rbpt_checker.sv =====
// port-level checks of the ray versus box test block, bound to the top level
`default_nettype none
`include "ray_box_plucker_test_defines.svh"

module rbpt_checker (
  input wire                                 clk,
  input wire                                 rst,
  input wire                                 s_axis_tvalid,
  input wire                                 s_axis_tready,
  input wire                                 m_axis_tvalid,
  input wire                                 m_axis_tready,
  input wire [rbpt_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata
);

  logic in_beat;
  assign in_beat = s_axis_tvalid & s_axis_tready;

  `RBPT_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  `RBPT_ASSERT_IMP(a_pad_zero, clk, rst, m_axis_tvalid, m_axis_tdata[rbpt_pkg::OUT_TDATA_BITS-1:1] == '0)

  `RBPT_ASSERT_IMP(a_stall_cause, clk, rst, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

  `RBPT_ASSERT_IMP(a_latency, clk, rst, $past(in_beat, 4) && $past(m_axis_tready, 3) && $past(m_axis_tready, 2) && $past(m_axis_tready, 1) && !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3) && !$past(rst, 4), m_axis_tvalid)

endmodule

bind ray_box_plucker_test rbpt_checker u_rbpt_checker (
  .clk(clk),
  .rst(rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

`default_nettype wire

// ===== test/ray_box_plucker_test_tb.sv =====
// self-checking testbench for the ray versus axis-aligned box test block
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rbpt_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int DB = DIR_BITS_DEF;
  localparam int IN_TDATA_BITS = ((3 * CB + 3 * DB + 3 * PLK_BITS + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [REG_IDX_BITS-1:0] REG_SPARE = 3'd7;
  localparam longint COORD_MIN = -(64'sd1 <<< (CB - 1));
  localparam longint COORD_MAX = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint DIR_MAX = (64'sd1 <<< (DB - 1)) - 1;
  localparam longint PLK_MAX = (64'sd1 <<< (PLK_BITS - 1)) - 1;

  typedef struct {
    logic signed [CB-1:0]       ox, oy, oz;
    logic signed [DB-1:0]       dx, dy, dz;
    logic signed [PLK_BITS-1:0] pxy, pxz, pyz;
    logic [SIGN_BITS-1:0]       sgn;
  } ray_t;

  typedef enum int {
    RAY_AIMED, RAY_NUDGED, RAY_AWAY, RAY_WRONG_CLASS, RAY_AXIS, RAY_NOISE
  } ray_kind_t;

  class hit_scoreboard;
    bit box_empty = 1'b1;
    longint lo[3], hi[3];
    bit hit_q[$];
    int errors, rays, hits;

    function void write_reg(logic [REG_IDX_BITS-1:0] idx, logic [CB-1:0] val);
      case (idx)
        REG_BOX_EMPTY:  box_empty = val[0];
        REG_BOX_X_LOW:  lo[0] = $signed(val);
        REG_BOX_X_HIGH: hi[0] = $signed(val);
        REG_BOX_Y_LOW:  lo[1] = $signed(val);
        REG_BOX_Y_HIGH: hi[1] = $signed(val);
        REG_BOX_Z_LOW:  lo[2] = $signed(val);
        REG_BOX_Z_HIGH: hi[2] = $signed(val);
        default: ;
      endcase
    endfunction

    // both silhouette edges of one coefficient; true means the ray passes outside
    function bit edge_cut(longint c, longint a, bit sign_a, longint plo, longint phi,
                          longint b, bit sign_b, longint qlo, longint qhi);
      longint near_side, far_side;
      near_side = c + a * (sign_a ? phi : plo) - b * (sign_b ? qlo : qhi);
      far_side  = c + a * (sign_a ? plo : phi) - b * (sign_b ? qhi : qlo);
      return (near_side < 0) || (far_side > 0);
    endfunction

    function void note_ray(ray_t r);
      longint ox, oy, oz, dx, dy, dz;
      bit sx, sy, sz, miss;
      ox = r.ox; oy = r.oy; oz = r.oz;
      dx = r.dx; dy = r.dy; dz = r.dz;
      sx = r.sgn[2]; sy = r.sgn[1]; sz = r.sgn[0];
      if (box_empty) begin
        miss = 1'b1;
      end else begin
        miss = (sx ? ox > hi[0] : ox < lo[0])
            || (sy ? oy > hi[1] : oy < lo[1])
            || (sz ? oz > hi[2] : oz < lo[2])
            || edge_cut(r.pxy, dx, sx, lo[1], hi[1], dy, sy, lo[0], hi[0])
            || edge_cut(r.pxz, dx, sx, lo[2], hi[2], dz, sz, lo[0], hi[0])
            || edge_cut(r.pyz, dy, sy, lo[2], hi[2], dz, sz, lo[1], hi[1]);
      end
      hit_q.push_back(!miss);
      rays++;
      if (!miss) hits++;
    endfunction

    function void check_hit(logic got);
      bit want;
      if (hit_q.size() == 0) begin
        errors++;
        if (errors <= 40) $display("%0t: hit beat with none pending, expected none, got %b",
                                   $time, got);
        return;
      end
      want = hit_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 40) $display("%0t: hit mismatch, expected %0d, got %b", $time, want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_BITS-1:0] s_axis_tdata = '0;
  logic [SIGN_BITS-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [REG_IDX_BITS-1:0] cfg_idx = '0;
  logic [CB-1:0] cfg_data = '0;

  hit_scoreboard sb = new;
  longint bx_lo[3], bx_hi[3];
  bit quiet;
  int stall_left;
  int cycle_count;

  ray_box_plucker_test uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // mostly short pauses, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      m_axis_tready <= 1'b0;
      stall_left <= gap_len() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_hit(m_axis_tdata[0]);
  end

  function automatic ray_t fill_ray(longint c, longint d, longint p, logic [2:0] cls);
    ray_t r;
    r.ox = CB'(c); r.oy = CB'(c); r.oz = CB'(c);
    r.dx = DB'(d); r.dy = DB'(d); r.dz = DB'(d);
    r.pxy = PLK_BITS'(p); r.pxz = PLK_BITS'(p); r.pyz = PLK_BITS'(p);
    r.sgn = cls;
    return r;
  endfunction

  // rays through a point of the box (often a face, edge or corner) or noise rays, with
  // coefficients that match the line unless a kind disturbs them
  function automatic ray_t gen_ray(ray_kind_t kind, int cls);
    ray_t r;
    longint o[3], d[3];
    longint lo, hi, t;
    logic [2:0] cls_bits;
    int keep;
    if (kind == RAY_NOISE) begin
      r.ox = CB'($urandom); r.oy = CB'($urandom); r.oz = CB'($urandom);
      r.dx = DB'($urandom); r.dy = DB'($urandom); r.dz = DB'($urandom);
      r.pxy = PLK_BITS'({$urandom, $urandom});
      r.pxz = PLK_BITS'({$urandom, $urandom});
      r.pyz = PLK_BITS'({$urandom, $urandom});
      r.sgn = SIGN_BITS'($urandom);
      return r;
    end
    keep = $urandom_range(0, 2);
    for (int a = 0; a < 3; a++) begin
      lo = (bx_lo[a] < bx_hi[a]) ? bx_lo[a] : bx_hi[a];
      hi = (bx_lo[a] < bx_hi[a]) ? bx_hi[a] : bx_lo[a];
      case ($urandom_range(0, 3))
        0: t = lo;
        1: t = hi;
        default: t = lo + longint'($urandom_range(0, int'(hi - lo)));
      endcase
      if (cls >= 0) begin
        d[a] = longint'($urandom_range(1, 65536));
        if (!cls[2-a]) d[a] = -d[a];
      end else begin
        case ($urandom_range(0, 7))
          0: d[a] = 0;
          1: d[a] = longint'($signed(DB'($urandom)));
          default: d[a] = longint'($urandom_range(0, 131072)) - 65536;
        endcase
      end
      if (kind == RAY_AXIS && a != keep) d[a] = 0;
      o[a] = t - ((d[a] * longint'($urandom_range(0, 255))) >>> 4);
      if (o[a] < COORD_MIN) o[a] = COORD_MIN;
      if (o[a] > COORD_MAX) o[a] = COORD_MAX;
      if (kind == RAY_AWAY) begin
        d[a] = -d[a];
        if (d[a] > DIR_MAX) d[a] = DIR_MAX;
      end
      cls_bits[2-a] = (d[a] > 0) ? 1'b1 : (d[a] < 0) ? 1'b0 : 1'($urandom);
    end
    if (cls >= 0) cls_bits = 3'(cls);
    if (kind == RAY_WRONG_CLASS) cls_bits = cls_bits ^ 3'($urandom_range(1, 7));
    r.ox = CB'(o[0]); r.oy = CB'(o[1]); r.oz = CB'(o[2]);
    r.dx = DB'(d[0]); r.dy = DB'(d[1]); r.dz = DB'(d[2]);
    r.pxy = PLK_BITS'(d[1] * o[0] - d[0] * o[1]);
    r.pxz = PLK_BITS'(d[2] * o[0] - d[0] * o[2]);
    r.pyz = PLK_BITS'(d[2] * o[1] - d[1] * o[2]);
    r.sgn = cls_bits;
    if (kind == RAY_NUDGED) begin
      case ($urandom_range(0, 2))
        0: r.pxy = r.pxy + PLK_BITS'(longint'($urandom_range(0, 8192)) - 4096);
        1: r.pxz = r.pxz + PLK_BITS'(longint'($urandom_range(0, 8192)) - 4096);
        default: r.pyz = r.pyz + PLK_BITS'(longint'($urandom_range(0, 8192)) - 4096);
      endcase
    end
    return r;
  endfunction

  task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= CB'(val);
    @(posedge clk);
    sb.write_reg(idx, CB'(val));
  endtask

  task automatic program_box(bit empty, bit spare);
    write_reg(REG_BOX_EMPTY, empty);
    write_reg(REG_BOX_X_LOW, bx_lo[0]);
    write_reg(REG_BOX_X_HIGH, bx_hi[0]);
    write_reg(REG_BOX_Y_LOW, bx_lo[1]);
    write_reg(REG_BOX_Y_HIGH, bx_hi[1]);
    write_reg(REG_BOX_Z_LOW, bx_lo[2]);
    write_reg(REG_BOX_Z_HIGH, bx_hi[2]);
    if (spare) write_reg(REG_SPARE, longint'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic send_ray(ray_t r);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 30) ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_TDATA_BITS'({r.pyz, r.pxz, r.pxy, r.dz, r.dy, r.dx, r.oz, r.oy, r.ox});
    s_axis_tuser <= r.sgn;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_ray(r);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.hit_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    ray_kind_t kind;
    int r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // box still empty from reset
    for (int i = 0; i < 3; i++) send_ray(gen_ray(RAY_AIMED, -1));
    drain();

    bx_lo[0] = -409600;  bx_hi[0] = 819200;
    bx_lo[1] = -204800;  bx_hi[1] = 614400;
    bx_lo[2] = -1024000; bx_hi[2] = 40960;
    program_box(1'b0, 1'b0);
    for (int c = 0; c < 8; c++) send_ray(gen_ray(RAY_AIMED, c));
    send_ray(gen_ray(RAY_WRONG_CLASS, -1));
    send_ray(gen_ray(RAY_WRONG_CLASS, 5));
    send_ray(gen_ray(RAY_AWAY, -1));
    send_ray(gen_ray(RAY_AXIS, -1));
    send_ray(gen_ray(RAY_NUDGED, -1));
    send_ray(gen_ray(RAY_NUDGED, 2));
    send_ray(fill_ray(COORD_MAX, DIR_MAX, PLK_MAX, 3'b111));
    send_ray(fill_ray(COORD_MIN, -DIR_MAX - 1, -PLK_MAX - 1, 3'b000));
    send_ray(fill_ray(0, 0, 0, 3'b010));
    send_ray(fill_ray(-1, -1, -1, 3'b101));
    send_ray(gen_ray(RAY_NOISE, -1));
    send_ray(gen_ray(RAY_NOISE, -1));
    drain();

    for (int p = 0; p < 7; p++) begin
      quiet = (p == 2 || p == 5);
      for (int a = 0; a < 3; a++) begin
        if (p == 2) begin
          bx_lo[a] = COORD_MIN;
          bx_hi[a] = COORD_MAX;
        end else begin
          bx_lo[a] = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
          bx_hi[a] = bx_lo[a] + longint'($urandom_range(0, (p == 5) ? 4096 : (1 << 20)));
        end
        if (p == 3) bx_hi[a] = bx_lo[a];
        if (p == 4 && (a == 0 || $urandom_range(0, 1) == 1)) begin
          bx_hi[a] = bx_lo[a] - longint'($urandom_range(1, 1 << 18));
        end
      end
      program_box(p == 0, p == 0);
      repeat (200) begin
        r = $urandom_range(0, 99);
        if (r < 45) kind = RAY_AIMED;
        else if (r < 55) kind = RAY_NUDGED;
        else if (r < 65) kind = RAY_AWAY;
        else if (r < 72) kind = RAY_WRONG_CLASS;
        else if (r < 80) kind = RAY_AXIS;
        else kind = RAY_NOISE;
        send_ray(gen_ray(kind, -1));
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d rays, %0d hits and %0d misses, over 9 box settings",
             sb.rays, sb.hits, sb.rays - sb.hits);
    $display("settings: empty, wide, full range, point, inverted and narrow boxes");
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
